// ===== design/trie_word_break_counter_assert.svh =====
// ----------------------------------------------------------------------------
// trie_word_break_counter_assert.svh
// Assertion macros used by the port checker of the word break counter.
// ----------------------------------------------------------------------------
`ifndef TRIE_WORD_BREAK_COUNTER_ASSERT_SVH
`define TRIE_WORD_BREAK_COUNTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TWBC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TWBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/twbc_pkg.sv =====
// ----------------------------------------------------------------------------
// twbc_pkg
// Shared constants, codes and types of the trie word break counter.
// ----------------------------------------------------------------------------
`default_nettype none

package twbc_pkg;

    localparam int MAX_NODES_DEF = 4096;
    localparam int MAX_TEXT_DEF  = 4096;
    localparam int ALPHABET_DEF  = 26;

    localparam int LETTER_W = 5;
    localparam int WAYS_W   = 30;
    localparam int ERR_W    = 2;

    localparam logic [WAYS_W-1:0] MODULUS = 30'd1000000007;

    localparam logic OP_DICT = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK   = 2'd0,
        ERR_DICT = 2'd1,
        ERR_TEXT = 2'd2
    } twbc_err_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DICT,
        ST_START,
        ST_CHD,
        ST_MRK,
        ST_ACC,
        ST_EMIT
    } twbc_state_t;

endpackage

`default_nettype wire

// ===== design/twbc_ram.sv =====
// ----------------------------------------------------------------------------
// twbc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module twbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/trie_word_break_counter.sv =====
// ----------------------------------------------------------------------------
// trie_word_break_counter
// Builds a trie from dictionary letters, stores text letters and counts the
// segmentations of each text into dictionary words, modulo 1000000007.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  input    | in        | in_valid/in_stall  | opcode, letter, last
//  result   | out       | out_valid/out_stall| ways, error_code
//
//  Dictionary letter: child read, then update. Text letter: stored when taken.
//  Last text letter: a start state, then per text position a walk of child read,
//  mark/ways read and accumulate for each trie edge, stopping on a missing edge or
//  a non-letter, then emit; the steps follow the text, child, mark/ways RAM reads.
//  After reset the child and mark RAMs are swept one entry per cycle, over all
//  MAX_NODES*ALPHABET child entries, with in_stall high throughout.
//  A waiting result holds the output register; new items are still taken,
//  but the next result holds in_stall high until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_word_break_counter
    import twbc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_TEXT  = MAX_TEXT_DEF,
    parameter int ALPHABET  = ALPHABET_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                opcode,
    input  wire logic [LETTER_W-1:0] letter,
    input  wire logic                last,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [WAYS_W-1:0]   ways,
    output logic      [ERR_W-1:0]    error_code
);

    localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int TXT_AW      = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int TLEN_W      = $clog2(MAX_TEXT + 1);

    localparam logic [CHILD_AW-1:0] CLR_LAST  = CHILD_AW'(CHILD_DEPTH - 1);
    localparam logic [CHILD_AW-1:0] ALPHA_A   = CHILD_AW'(ALPHABET);
    localparam logic [TLEN_W-1:0]   TEXT_FULL = TLEN_W'(MAX_TEXT);

    twbc_state_t state_reg, state_next;

    logic [CHILD_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [NODE_W-1:0]   nodes_reg, nodes_next;
    logic                dict_ovf_reg, dict_ovf_next;
    logic [TLEN_W-1:0]   text_len_reg, text_len_next;
    logic                text_ovf_reg, text_ovf_next;
    logic                out_valid_reg, out_valid_next;

    logic [CHILD_AW-1:0] slot_reg, slot_next;
    logic                dlast_reg, dlast_next;
    logic [TLEN_W-1:0]   row_reg, row_next;
    logic [TLEN_W-1:0]   col_reg, col_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [WAYS_W-1:0]   sum_reg, sum_next;
    logic [WAYS_W-1:0]   res_ways_reg, res_ways_next;
    twbc_err_t           res_err_reg, res_err_next;
    logic [WAYS_W-1:0]   ways_reg, ways_next;
    twbc_err_t           err_reg, err_next;

    // memory ports
    logic                ch_we;
    logic [CHILD_AW-1:0] ch_waddr, ch_raddr;
    logic [NODE_W-1:0]   ch_wdata, ch_rdata;
    logic                mk_we;
    logic [NODE_W-1:0]   mk_waddr, mk_raddr;
    logic                mk_wdata, mk_rdata;
    logic                tx_we;
    logic [TXT_AW-1:0]   tx_waddr, tx_raddr;
    logic [LETTER_W-1:0] tx_wdata, tx_rdata;
    logic                wy_we;
    logic [TLEN_W-1:0]   wy_waddr, wy_raddr;
    logic [WAYS_W-1:0]   wy_wdata, wy_rdata;

    logic                load_out;
    logic                row_done;
    logic [WAYS_W-1:0]   row_sum;
    logic                hit;
    logic                ovf_now;
    logic [NODE_W-1:0]   new_node;
    logic [WAYS_W:0]     add_wide;
    logic [WAYS_W-1:0]   add_mod;

    twbc_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
        .clk   (clk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .raddr (ch_raddr),
        .rdata (ch_rdata)
    );

    twbc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark (
        .clk   (clk),
        .we    (mk_we),
        .waddr (mk_waddr),
        .wdata (mk_wdata),
        .raddr (mk_raddr),
        .rdata (mk_rdata)
    );

    twbc_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_TEXT)) u_text (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    twbc_ram #(.WIDTH(WAYS_W), .DEPTH(MAX_TEXT + 1)) u_ways (
        .clk   (clk),
        .we    (wy_we),
        .waddr (wy_waddr),
        .wdata (wy_wdata),
        .raddr (wy_raddr),
        .rdata (wy_rdata)
    );

    // modular add of the running sum and the ways entry after this word
    always_comb
    begin
        add_wide = {1'b0, sum_reg} + {1'b0, wy_rdata};
        if (add_wide >= {1'b0, MODULUS})
        begin
            add_mod = WAYS_W'(add_wide - {1'b0, MODULUS});
        end
        else
        begin
            add_mod = WAYS_W'(add_wide);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cursor_next    = cursor_reg;
        nodes_next     = nodes_reg;
        dict_ovf_next  = dict_ovf_reg;
        text_len_next  = text_len_reg;
        text_ovf_next  = text_ovf_reg;
        slot_next      = slot_reg;
        dlast_next     = dlast_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        node_next      = node_reg;
        sum_next       = sum_reg;
        res_ways_next  = res_ways_reg;
        res_err_next   = res_err_reg;

        ch_we    = 1'b0;
        ch_waddr = slot_reg;
        ch_wdata = '0;
        ch_raddr = slot_reg;
        mk_we    = 1'b0;
        mk_waddr = cursor_reg;
        mk_wdata = 1'b1;
        mk_raddr = node_reg;
        tx_we    = 1'b0;
        tx_waddr = TXT_AW'(text_len_reg);
        tx_wdata = letter;
        tx_raddr = TXT_AW'(col_reg);
        wy_we    = 1'b0;
        wy_waddr = row_reg;
        wy_wdata = sum_reg;
        wy_raddr = col_reg + 1'b1;

        in_stall = (state_reg != ST_IDLE);
        load_out = 1'b0;
        row_done = 1'b0;
        row_sum  = sum_reg;
        hit      = (ch_rdata != '0);
        ovf_now  = 1'b0;
        new_node = ch_rdata;

        case (state_reg)
            ST_CLEAR:
            begin
                ch_we    = 1'b1;
                ch_waddr = clr_cnt_reg;
                ch_wdata = '0;
                mk_we    = (clr_cnt_reg < CHILD_AW'(MAX_NODES));
                mk_waddr = NODE_W'(clr_cnt_reg);
                mk_wdata = 1'b0;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_DICT)
                    begin
                        if (!dict_ovf_reg && (int'(letter) < ALPHABET))
                        begin
                            slot_next  = CHILD_AW'(cursor_reg) * ALPHA_A
                                         + CHILD_AW'(letter);
                            ch_raddr   = slot_next;
                            dlast_next = last;
                            state_next = ST_DICT;
                        end
                        else if (last)
                        begin
                            mk_we       = !dict_ovf_reg;
                            mk_waddr    = cursor_reg;
                            cursor_next = '0;
                        end
                    end
                    else
                    begin
                        if (text_len_reg < TEXT_FULL)
                        begin
                            tx_we         = 1'b1;
                            text_len_next = text_len_reg + 1'b1;
                        end
                        else
                        begin
                            text_ovf_next = 1'b1;
                        end
                        if (last)
                        begin
                            res_ways_next = '0;
                            if (dict_ovf_reg)
                            begin
                                res_err_next = ERR_DICT;
                                state_next   = ST_EMIT;
                            end
                            else if (text_ovf_reg || (text_len_reg == TEXT_FULL))
                            begin
                                res_err_next = ERR_TEXT;
                                state_next   = ST_EMIT;
                            end
                            else
                            begin
                                res_err_next = ERR_OK;
                                state_next   = ST_START;
                            end
                        end
                    end
                end
            end

            ST_DICT:
            begin
                if (!hit)
                begin
                    if (int'(nodes_reg) >= MAX_NODES - 1)
                    begin
                        ovf_now       = 1'b1;
                        dict_ovf_next = 1'b1;
                    end
                    else
                    begin
                        new_node   = nodes_reg + 1'b1;
                        nodes_next = new_node;
                        ch_we      = 1'b1;
                        ch_waddr   = slot_reg;
                        ch_wdata   = new_node;
                    end
                end
                if (!ovf_now)
                begin
                    cursor_next = new_node;
                end
                if (dlast_reg)
                begin
                    mk_we       = !ovf_now;
                    mk_waddr    = new_node;
                    cursor_next = '0;
                end
                state_next = ST_IDLE;
            end

            ST_START:
            begin
                // ways after the full text is one
                wy_we     = 1'b1;
                wy_waddr  = text_len_reg;
                wy_wdata  = WAYS_W'(1);
                row_next  = text_len_reg - 1'b1;
                col_next  = text_len_reg - 1'b1;
                node_next = '0;
                sum_next  = '0;
                tx_raddr  = TXT_AW'(text_len_reg - 1'b1);
                state_next = ST_CHD;
            end

            ST_CHD:
            begin
                if (int'(tx_rdata) >= ALPHABET)
                begin
                    row_done = 1'b1;
                end
                else
                begin
                    ch_raddr   = CHILD_AW'(node_reg) * ALPHA_A + CHILD_AW'(tx_rdata);
                    state_next = ST_MRK;
                end
            end

            ST_MRK:
            begin
                if (!hit)
                begin
                    row_done = 1'b1;
                end
                else
                begin
                    node_next  = ch_rdata;
                    mk_raddr   = ch_rdata;
                    wy_raddr   = col_reg + 1'b1;
                    state_next = ST_ACC;
                end
            end

            ST_ACC:
            begin
                if (mk_rdata)
                begin
                    row_sum = add_mod;
                end
                sum_next = row_sum;
                if (col_reg + 1'b1 == text_len_reg)
                begin
                    row_done = 1'b1;
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    tx_raddr   = TXT_AW'(col_reg + 1'b1);
                    state_next = ST_CHD;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out      = 1'b1;
                    text_len_next = '0;
                    text_ovf_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // close the row: store its count, then start the position before it or emit at row zero
        if (row_done)
        begin
            wy_we    = 1'b1;
            wy_waddr = row_reg;
            wy_wdata = row_sum;
            if (row_reg == '0)
            begin
                res_ways_next = row_sum;
                state_next    = ST_EMIT;
            end
            else
            begin
                row_next   = row_reg - 1'b1;
                col_next   = row_reg - 1'b1;
                node_next  = '0;
                sum_next   = '0;
                tx_raddr   = TXT_AW'(row_reg - 1'b1);
                state_next = ST_CHD;
            end
        end

        out_valid_next = out_valid_reg && out_stall;
        ways_next      = ways_reg;
        err_next       = err_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            ways_next      = res_ways_reg;
            err_next       = res_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cursor_reg    <= '0;
            nodes_reg     <= '0;
            dict_ovf_reg  <= 1'b0;
            text_len_reg  <= '0;
            text_ovf_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cursor_reg    <= cursor_next;
            nodes_reg     <= nodes_next;
            dict_ovf_reg  <= dict_ovf_next;
            text_len_reg  <= text_len_next;
            text_ovf_reg  <= text_ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        dlast_reg    <= dlast_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        node_reg     <= node_next;
        sum_reg      <= sum_next;
        res_ways_reg <= res_ways_next;
        res_err_reg  <= res_err_next;
        ways_reg     <= ways_next;
        err_reg      <= err_next;
    end

    assign out_valid  = out_valid_reg;
    assign ways       = ways_reg;
    assign error_code = err_reg;

endmodule

`default_nettype wire

// ===== design/twbc_checker.sv =====
// ----------------------------------------------------------------------------
// twbc_checker
// Port-level checks of the word break counter result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trie_word_break_counter_assert.svh"

module twbc_port_checker
    import twbc_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                opcode,
    input wire logic [LETTER_W-1:0] letter,
    input wire logic                last,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [WAYS_W-1:0]   ways,
    input wire logic [ERR_W-1:0]    error_code
);

    logic unused_in;

    assign unused_in = in_valid ^ in_stall ^ opcode ^ (^letter) ^ last;

    `TWBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(ways) && $stable(error_code), "result changed while stalled")
    `TWBC_ASSERT(a_err_legal, out_valid, (error_code == ERR_OK) || (error_code == ERR_DICT) || (error_code == ERR_TEXT), "illegal error code")
    `TWBC_ASSERT(a_err_zero, out_valid && (error_code != ERR_OK), ways == '0, "error result with nonzero count")
    `TWBC_ASSERT(a_ways_mod, out_valid, ways < MODULUS, "count not reduced")

endmodule

bind trie_word_break_counter twbc_port_checker u_twbc_port_checker (.*);

`default_nettype wire

// ===== test/twbc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twbc_checker
// Watches both channels of the word break counter, keeps its own trie and
// text copy, predicts each segmentation count and compares it field by field.
// ----------------------------------------------------------------------------
module twbc_checker
    import twbc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic                opcode,
    input  wire logic [LETTER_W-1:0] letter,
    input  wire logic                last,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire logic [WAYS_W-1:0]   ways,
    input  wire logic [ERR_W-1:0]    error_code,
    output int                       fail_count,
    output int                       pending
);

    localparam int NODES = MAX_NODES_DEF;
    localparam int TEXT  = MAX_TEXT_DEF;
    localparam int ABC   = ALPHABET_DEF;
    localparam int unsigned PRIME = 32'd1000000007;

    typedef struct packed {
        logic [WAYS_W-1:0] count;
        twbc_err_t         err;
    } split_count_t;

    split_count_t     split_counts_q[$];
    logic [11:0]      child_tbl [NODES*ABC];
    bit               word_end [NODES];
    logic [LETTER_W-1:0] text_buf [TEXT];
    int unsigned      suffix_ways [TEXT+1];
    int               node_count;
    int               cursor;
    int               text_len;
    bit               dict_full;
    bit               text_long;

    initial
    begin
        for (int k = 0; k < NODES*ABC; k++)
            child_tbl[k] = '0;
        for (int k = 0; k < NODES; k++)
            word_end[k] = 1'b0;
        node_count = 0;
        cursor     = 0;
        text_len   = 0;
        dict_full  = 1'b0;
        text_long  = 1'b0;
        fail_count = 0;
        pending    = 0;
    end

    function automatic void insert_letter(int code, bit fin);
        int slot;
        int nxt;
        if (!dict_full && code < ABC)
        begin
            slot = cursor*ABC + code;
            nxt  = child_tbl[slot];
            if (nxt == 0)
            begin
                if (node_count + 1 >= NODES)
                    dict_full = 1'b1;
                else
                begin
                    node_count++;
                    child_tbl[slot] = node_count[11:0];
                    nxt = node_count;
                end
            end
            if (!dict_full)
                cursor = nxt;
        end
        if (fin)
        begin
            if (!dict_full)
                word_end[cursor] = 1'b1;
            cursor = 0;
        end
    endfunction

    // fill counts from the tail back to position zero
    function automatic int unsigned count_splits();
        int node;
        int unsigned total;
        suffix_ways[text_len] = 1;
        for (int i = text_len - 1; i >= 0; i--)
        begin
            node  = 0;
            total = 0;
            for (int j = i; j < text_len; j++)
            begin
                if (text_buf[j] >= ABC)
                    break;
                node = child_tbl[node*ABC + text_buf[j]];
                if (node == 0)
                    break;
                if (word_end[node])
                begin
                    total += suffix_ways[j+1];
                    if (total >= PRIME)
                        total -= PRIME;
                end
            end
            suffix_ways[i] = total;
        end
        return suffix_ways[0];
    endfunction

    always @(posedge clk)
    begin
        split_count_t exp_item;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (split_counts_q.size() == 0)
                begin
                    $display("%0t: unexpected result ways=%0d error_code=%0d",
                             $time, ways, error_code);
                    fail_count++;
                end
                else
                begin
                    exp_item = split_counts_q.pop_front();
                    if (ways !== exp_item.count || error_code !== exp_item.err)
                    begin
                        $display("%0t: mismatch: expected ways=%0d error_code=%0d, actual ways=%0d error_code=%0d",
                                 $time, exp_item.count, exp_item.err, ways, error_code);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (opcode == OP_DICT)
                    insert_letter(letter, last);
                else
                begin
                    if (text_len < TEXT)
                    begin
                        text_buf[text_len] = letter;
                        text_len++;
                    end
                    else
                        text_long = 1'b1;
                    if (last)
                    begin
                        exp_item.count = '0;
                        if (dict_full)
                            exp_item.err = ERR_DICT;
                        else if (text_long)
                            exp_item.err = ERR_TEXT;
                        else
                        begin
                            exp_item.err   = ERR_OK;
                            exp_item.count = count_splits();
                        end
                        split_counts_q.push_back(exp_item);
                        text_len  = 0;
                        text_long = 1'b0;
                    end
                end
            end
            pending = split_counts_q.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives dictionary words and texts into the word break counter with random
// gaps and output stalls, then gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;
    import twbc_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                opcode;
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                out_valid;
    logic                out_stall;
    logic [WAYS_W-1:0]   ways;
    logic [ERR_W-1:0]    error_code;
    int                  fail_count;
    int                  pending;
    bit                  calm;
    int                  stall_left;
    int                  sent;

    trie_word_break_counter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .letter     (letter),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ways       (ways),
        .error_code (error_code)
    );

    twbc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .letter     (letter),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ways       (ways),
        .error_code (error_code),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;
    always
        #2 clk = ~clk;

    // receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (calm || stall_left == 0)
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 8);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
        else
        begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // enter and leave at a falling edge
    task automatic send_item(logic op, logic [LETTER_W-1:0] code, logic fin);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        letter   <= code;
        last     <= fin;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        sent++;
        @(negedge clk);
    endtask

    // '#' stands for the top letter code, others map from 'a'
    task automatic send_word(logic op, string s);
        logic [LETTER_W-1:0] code;
        for (int i = 0; i < s.len(); i++)
        begin
            code = (s[i] == "#") ? 5'd31 : LETTER_W'(s[i] - 8'd97);
            send_item(op, code, i == s.len() - 1);
        end
    endtask

    task automatic send_random_seq(logic op, int len);
        logic [LETTER_W-1:0] code;
        for (int i = 0; i < len; i++)
        begin
            code = ($urandom_range(0, 15) == 0) ? LETTER_W'($urandom_range(0, 31))
                                                : LETTER_W'($urandom_range(0, 3));
            send_item(op, code, i == len - 1);
        end
    endtask

    task automatic send_random_mix(int upto);
        while (sent < upto)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_random_seq(OP_DICT, $urandom_range(1, 5));
                5, 6, 7, 8:    send_random_seq(OP_TEXT, $urandom_range(1, 10));
                default:       send_item(logic'($urandom_range(0, 1)),
                                         LETTER_W'($urandom_range(0, 31)),
                                         logic'($urandom_range(0, 1)));
            endcase
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_DICT;
        letter     = '0;
        last       = 1'b0;
        out_stall  = 1'b0;
        calm       = 1'b0;
        stall_left = 0;
        sent       = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words and texts
        send_word(OP_DICT, "a");
        send_word(OP_DICT, "ab");
        send_word(OP_DICT, "b");
        send_word(OP_DICT, "z");
        send_word(OP_DICT, "a#");
        send_word(OP_DICT, "#");
        send_word(OP_DICT, "{b");
        send_word(OP_TEXT, "abab");
        send_word(OP_TEXT, "z");
        send_word(OP_TEXT, "a#b");
        send_word(OP_TEXT, "{");
        send_word(OP_TEXT, "x");

        // hold until every result is out
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        sent = 0;
        send_random_mix(1000);
        send_random_seq(OP_TEXT, 3);

        // back to back with no gaps or output stalls for the tail of the run
        calm = 1'b1;
        send_random_mix(1115);
        send_random_seq(OP_TEXT, 3);
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/twbc_pkg.sv
design/twbc_ram.sv
design/trie_word_break_counter.sv
design/twbc_checker.sv
test/twbc_checker.sv
test/testbench.sv
